// ----- rtl/spi_rb_pkg.sv -----
`default_nettype none

package spi_rb_pkg;

    // Register offsets inside a channel window
    localparam logic [7:0] OFF_DATA   = 8'h00;
    localparam logic [7:0] OFF_CTRL   = 8'h08;
    localparam logic [7:0] OFF_CTRL2  = 8'h0C;
    localparam logic [7:0] OFF_STATUS = 8'h50;
    localparam logic [7:0] OFF_CLEAR  = 8'h68;

    // Word index of the control-2 register in the shadow
    localparam logic [5:0] CTRL2_WORD = 6'd3;

    // Bit positions
    localparam int BIT_ENABLE      = 0;
    localparam int BIT_LOOP_INV    = 16;
    localparam int BIT_LOOP_DIRECT = 17;
    localparam int FLAG_DATA_READY = 23;
    localparam int FLAG_TX_EMPTY   = 29;
    localparam int FLAG_RX_FULL    = 31;

    localparam int DATA_W = 32;
    localparam int BYTE_W = 8;

    // Decoded request, handed from the top level to the channel registers
    typedef struct packed {
        logic wr;         // write request
        logic hit_data;   // exact data offset
        logic hit_ctrl;   // exact control offset
        logic hit_ctrl2;  // exact control-2 offset
        logic hit_clear;  // exact status-clear offset
        logic hit_word3;  // any byte of the control-2 word
    } t_dec;

endpackage

`default_nettype wire

// ----- rtl/spi_register_block_loopback.sv -----
// SPI register block with internal loopback.
// Input channel: one bus request per accepted item (i_in_valid high, o_in_stall
//   low): command (0 read, 1 write), channel, byte offset, write data and the
//   byte the external line would return.
// Output channel: one result per request on o_read_data, qualified by
//   o_out_valid and held while i_out_stall is high. Reads return status,
//   the receive echo or the shadow word; writes and out-of-window accesses
//   return zero.
// Pipeline: read stage, then output register. Throughput: one request
//   per cycle when not stalled, set by the shadow memory's one read/write port.
// Reset: flags, receive registers and enables clear at once; then a clearing
//   sweep writes zero into the shadow memory, one word a cycle, covering all
//   CHANNELS * 2**clog2(SHADOW_DEPTH) words (64 at the defaults). During the
//   sweep o_in_stall is high.
// Stall: a request waiting in the read stage and one in the output register
//   absorb a stalled receiver; outside the sweep o_in_stall rises only when both
//   are occupied and i_out_stall is high.
`default_nettype none

module spi_register_block_loopback
    import spi_rb_pkg::*;
#(
    parameter int CHANNELS     = 2,
    parameter int SHADOW_DEPTH = 28
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_command,
    input  wire logic        i_channel,
    input  wire logic [7:0]  i_byte_offset,
    input  wire logic [31:0] i_write_data,
    input  wire logic [7:0]  i_line_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_read_data
);

    localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int WORD_W  = $clog2(SHADOW_DEPTH);
    localparam int ADDR_W  = CH_W + WORD_W;
    localparam int MEM_DEP = CHANNELS << WORD_W;

    // pipeline control
    logic              r_s1_valid;
    logic              r_s1_use_mem;
    logic [DATA_W-1:0] r_s1_side;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_read_data;

    logic              mem_busy;
    logic [DATA_W-1:0] mem_rdata;
    logic              out_free, s1_move, in_ready, accept;

    // request decode
    logic              ch_ok, word_ok, in_range, req_ok;
    logic [CH_W-1:0]   ch_idx;
    logic [ADDR_W-1:0] mem_addr;
    t_dec              dec;
    logic [DATA_W-1:0] status_word, rx_word;
    logic              rd_status, rd_data;

    always_comb begin
        ch_ok    = {31'b0, i_channel} < CHANNELS;
        word_ok  = {26'b0, i_byte_offset[7:2]} < SHADOW_DEPTH;
        in_range = ch_ok & word_ok;
        ch_idx   = CH_W'(i_channel);
        mem_addr = {ch_idx, i_byte_offset[2 +: WORD_W]};

        dec.wr        = i_command;
        dec.hit_data  = i_byte_offset == OFF_DATA;
        dec.hit_ctrl  = i_byte_offset == OFF_CTRL;
        dec.hit_ctrl2 = i_byte_offset == OFF_CTRL2;
        dec.hit_clear = i_byte_offset == OFF_CLEAR;
        dec.hit_word3 = i_byte_offset[7:2] == CTRL2_WORD;

        rd_status = i_byte_offset == OFF_STATUS;
        rd_data   = dec.hit_data;
    end

    // handshake: s1 holds the memory read, output register after it
    always_comb begin
        out_free   = !r_out_valid || !i_out_stall;
        s1_move    = r_s1_valid && out_free;
        in_ready   = !mem_busy && (!r_s1_valid || out_free);
        accept     = i_in_valid && in_ready;
        req_ok     = accept && in_range;
        o_in_stall = !in_ready;
    end

    spi_rb_shadow_mem #(
        .DEPTH  (MEM_DEP),
        .ADDR_W (ADDR_W)
    ) u_shadow (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (req_ok && i_command),
        .i_rd_en (req_ok && !i_command),
        .i_addr  (mem_addr),
        .i_wdata (i_write_data),
        .o_rdata (mem_rdata),
        .o_busy  (mem_busy)
    );

    spi_rb_chan_regs #(
        .CHANNELS (CHANNELS),
        .CH_W     (CH_W)
    ) u_chan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (req_ok),
        .i_dec         (dec),
        .i_ch          (ch_idx),
        .i_wdata       (i_write_data),
        .i_line_byte   (i_line_byte),
        .o_status_word (status_word),
        .o_rx_word     (rx_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            // status and echo come from flops now; other reads wait on memory
            r_s1_use_mem <= in_range && !i_command && !rd_status && !rd_data;
            if (!in_range || i_command) begin
                r_s1_side <= '0;
            end else if (rd_status) begin
                r_s1_side <= status_word;
            end else begin
                r_s1_side <= rx_word;
            end
        end
        if (s1_move) begin
            r_read_data <= r_s1_use_mem ? mem_rdata : r_s1_side;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_read_data;

endmodule

`default_nettype wire

// ----- rtl/spi_rb_shadow_mem.sv -----
`default_nettype none

module spi_rb_shadow_mem
    import spi_rb_pkg::*;
#(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_wr_en,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire logic [DATA_W-1:0] i_wdata,
    output logic      [DATA_W-1:0] o_rdata,
    output logic                   o_busy
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;
    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;

    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;

    // clearing sweep owns the write port after reset
    always_comb begin
        we    = r_clr_busy | i_wr_en;
        waddr = r_clr_busy ? r_clr_addr : i_addr;
        wdata = r_clr_busy ? '0 : i_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (i_rd_en) begin
            r_rdata <= mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_clr_busy;

endmodule

`default_nettype wire

// ----- rtl/spi_rb_chan_regs.sv -----
`default_nettype none

module spi_rb_chan_regs
    import spi_rb_pkg::*;
#(
    parameter int CHANNELS = 2,
    parameter int CH_W     = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire t_dec              i_dec,
    input  wire logic [CH_W-1:0]   i_ch,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [BYTE_W-1:0] i_line_byte,
    output logic      [DATA_W-1:0] o_status_word,
    output logic      [DATA_W-1:0] o_rx_word
);

    logic [DATA_W-1:0]   r_rx_hold [CHANNELS];
    logic [DATA_W-1:0]   n_rx_hold [CHANNELS];
    logic [CHANNELS-1:0] r_enabled, n_enabled;
    logic [CHANNELS-1:0] r_loop, n_loop;
    logic [CHANNELS-1:0] r_inv, n_inv;       // copy of shadow word 3 bit 16
    logic [CHANNELS-1:0] r_tx_empty, n_tx_empty;
    logic [CHANNELS-1:0] r_rx_full, n_rx_full;
    logic [CHANNELS-1:0] r_rdy, n_rdy;

    always_comb begin
        n_rx_hold  = r_rx_hold;
        n_enabled  = r_enabled;
        n_loop     = r_loop;
        n_inv      = r_inv;
        n_tx_empty = r_tx_empty;
        n_rx_full  = r_rx_full;
        n_rdy      = r_rdy;
        if (i_en && i_dec.wr) begin
            if (i_dec.hit_word3) begin
                n_inv[i_ch] = i_wdata[BIT_LOOP_INV];
            end
            priority if (i_dec.hit_ctrl) begin
                n_enabled[i_ch] = i_wdata[BIT_ENABLE];
                if (i_wdata[BIT_ENABLE]) begin
                    n_tx_empty[i_ch] = 1'b1;
                    n_rx_full[i_ch]  = 1'b0;
                end else begin
                    n_tx_empty[i_ch] = 1'b0;
                    n_rx_full[i_ch]  = 1'b0;
                    n_rdy[i_ch]      = 1'b0;
                end
            end else if (i_dec.hit_ctrl2) begin
                n_loop[i_ch] = i_wdata[BIT_LOOP_INV] | i_wdata[BIT_LOOP_DIRECT];
            end else if (i_dec.hit_data) begin
                // inverting loopback checks the old word 3
                if (r_inv[i_ch]) begin
                    n_rx_hold[i_ch] = {{(DATA_W-BYTE_W){1'b0}}, ~i_wdata[BYTE_W-1:0]};
                end else if (r_loop[i_ch]) begin
                    n_rx_hold[i_ch] = i_wdata;
                end else begin
                    n_rx_hold[i_ch] = DATA_W'(i_line_byte);
                end
                n_tx_empty[i_ch] = 1'b1;
                n_rx_full[i_ch]  = 1'b1;
                n_rdy[i_ch]      = 1'b1;
            end else if (i_dec.hit_clear) begin
                n_tx_empty[i_ch] = (r_tx_empty[i_ch] & ~i_wdata[FLAG_TX_EMPTY])
                                   | r_enabled[i_ch];
                n_rx_full[i_ch]  = r_rx_full[i_ch] & ~i_wdata[FLAG_RX_FULL];
                n_rdy[i_ch]      = r_rdy[i_ch] & ~i_wdata[FLAG_DATA_READY];
            end else begin
                n_loop = r_loop;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_rx_hold[i] <= '0;
            end
            r_enabled  <= '0;
            r_loop     <= '0;
            r_inv      <= '0;
            r_tx_empty <= '0;
            r_rx_full  <= '0;
            r_rdy      <= '0;
        end else begin
            r_rx_hold  <= n_rx_hold;
            r_enabled  <= n_enabled;
            r_loop     <= n_loop;
            r_inv      <= n_inv;
            r_tx_empty <= n_tx_empty;
            r_rx_full  <= n_rx_full;
            r_rdy      <= n_rdy;
        end
    end

    always_comb begin
        o_status_word                  = '0;
        o_status_word[FLAG_RX_FULL]    = r_rx_full[i_ch];
        o_status_word[FLAG_TX_EMPTY]   = r_tx_empty[i_ch];
        o_status_word[FLAG_DATA_READY] = r_rdy[i_ch];
        o_rx_word                      = r_rx_hold[i_ch];
    end

endmodule

`default_nettype wire

// ----- verif/spi_register_block_loopback_test.sv -----
`default_nettype none

module spi_register_block_loopback_test;
    timeunit 1ns;
    timeprecision 1ps;

    import spi_rb_pkg::*;

    // Bus access kinds
    localparam bit CMD_READ  = 1'b0;
    localparam bit CMD_WRITE = 1'b1;

    // Geometry of the block as instantiated
    localparam int NUM_CHANNELS = 2;
    localparam int SHADOW_WORDS = 28;

    // Run shaping
    localparam int RANDOM_REQUESTS = 1250;
    localparam int QUIET_TAIL      = 150;    // last requests run with no idling
    localparam int HOLD_OFF_AT     = 200;    // requests taken before the long hold-off
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 16;     // pad generously beyond the pipeline latency
    localparam int unsigned CYCLE_LIMIT = 300000;

    localparam logic [31:0] TX_EMPTY_MASK = 32'h1 << FLAG_TX_EMPTY;
    localparam logic [31:0] RX_FULL_MASK  = 32'h1 << FLAG_RX_FULL;
    localparam logic [31:0] READY_MASK    = 32'h1 << FLAG_DATA_READY;

    typedef struct packed {
        bit          cmd;
        bit          ch;
        logic [7:0]  off;
        logic [31:0] wdata;
        logic [7:0]  line;
    } t_spi_request;

    // Tracks the register state of both channels and the readback each
    // accepted request should produce, oldest first.
    class t_readback_book;
        logic [31:0] shadow [NUM_CHANNELS][SHADOW_WORDS];
        logic [31:0] flags [NUM_CHANNELS];
        logic [31:0] rx_hold [NUM_CHANNELS];
        bit          enabled [NUM_CHANNELS];
        bit          loop_on [NUM_CHANNELS];
        logic [31:0] readback_q [$];
        int          errors;

        function new();
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                for (int w = 0; w < SHADOW_WORDS; w++) shadow[c][w] = '0;
                flags[c]   = '0;
                rx_hold[c] = '0;
                enabled[c] = 1'b0;
                loop_on[c] = 1'b0;
            end
            errors = 0;
        endfunction

        function int outstanding();
            return readback_q.size();
        endfunction

        // Update state for one accepted request and queue its readback.
        function void note_request(t_spi_request req);
            logic [31:0] readback;
            int          c;
            int          w;
            readback = '0;
            c = int'(req.ch);
            w = int'(req.off[7:2]);
            // word index past the shadow: reads zero, writes dropped
            if (w < SHADOW_WORDS) begin
                if (req.cmd == CMD_WRITE) begin
                    shadow[c][w] = req.wdata;
                    if (req.off == OFF_CTRL) begin
                        enabled[c] = req.wdata[BIT_ENABLE];
                        if (enabled[c]) begin
                            flags[c] = (flags[c] | TX_EMPTY_MASK) & ~RX_FULL_MASK;
                        end else begin
                            flags[c] = '0;
                        end
                    end else if (req.off == OFF_CTRL2) begin
                        loop_on[c] = req.wdata[BIT_LOOP_INV] | req.wdata[BIT_LOOP_DIRECT];
                    end else if (req.off == OFF_DATA) begin
                        // inverting mode follows the shadow word, not the latch
                        if (shadow[c][CTRL2_WORD][BIT_LOOP_INV]) begin
                            rx_hold[c] = {24'h0, ~req.wdata[7:0]};
                        end else if (loop_on[c]) begin
                            rx_hold[c] = req.wdata;
                        end else begin
                            rx_hold[c] = {24'h0, req.line};
                        end
                        flags[c] = flags[c] | TX_EMPTY_MASK | RX_FULL_MASK | READY_MASK;
                    end else if (req.off == OFF_CLEAR) begin
                        flags[c] = flags[c] & ~req.wdata;
                        if (enabled[c]) flags[c] = flags[c] | TX_EMPTY_MASK;
                    end
                end else begin
                    if (req.off == OFF_STATUS) begin
                        readback = flags[c];
                    end else if (req.off == OFF_DATA) begin
                        readback = rx_hold[c];
                    end else begin
                        readback = shadow[c][w];
                    end
                end
            end
            readback_q.push_back(readback);
        endfunction

        function void check_readback(logic [31:0] actual);
            logic [31:0] want;
            if (readback_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, actual %08h", $time, actual);
            end else begin
                want = readback_q.pop_front();
                if (actual !== want) begin
                    errors++;
                    $display("%0t: read_data mismatch, expected %08h actual %08h",
                             $time, want, actual);
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_command;
    logic        i_channel;
    logic [7:0]  i_byte_offset;
    logic [31:0] i_write_data;
    logic [7:0]  i_line_byte;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_read_data;

    spi_register_block_loopback #(
        .CHANNELS    (NUM_CHANNELS),
        .SHADOW_DEPTH(SHADOW_WORDS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_channel    (i_channel),
        .i_byte_offset(i_byte_offset),
        .i_write_data (i_write_data),
        .i_line_byte  (i_line_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_read_data  (o_read_data)
    );

    t_readback_book book = new();

    // Offsets with side effects or special reads
    logic [7:0] hot_offsets [5] = '{OFF_DATA, OFF_CTRL, OFF_CTRL2, OFF_STATUS, OFF_CLEAR};

    int          requests_taken = 0;
    bit          quiet_tail     = 1'b0;   // no idling on either side once set
    int          send_idle_pct  = 10;
    int unsigned cycle_count    = 0;

    // 8 ns clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog: CYCLE_LIMIT leaves ample room for the slowest legal run,
    // including the post-reset clearing sweep and the long hold-off.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result monitor: a result moves on an edge with valid high and stall low.
    // i_out_stall only changes on the falling edge, so it is stable here.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            book.check_readback(o_read_data);
        end
    end

    // Receiver: random stall bursts of randomly changing density, one
    // long hold-off so the pipeline fills and pushes back on the sender, and
    // a calm tail with no stalls at all.
    initial begin
        int  stall_pct;
        int  window;
        bit  held_off;
        stall_pct = 0;
        window    = 0;
        held_off  = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            window++;
            if (window >= 64) begin
                window = 0;
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 10;
                    default: stall_pct = 35;
                endcase
            end
            if (quiet_tail) begin
                i_out_stall <= 1'b0;
            end else if (!held_off && requests_taken >= HOLD_OFF_AT) begin
                held_off = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else if ($urandom_range(0, 99) < stall_pct) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Present one request from a falling edge, hold it until accepted, then
    // maybe leave a gap. Valid stays high between back-to-back requests.
    task automatic send_request(input bit cmd, input bit ch, input logic [7:0] off,
                                input logic [31:0] wdata, input logic [7:0] line);
        t_spi_request req;
        req.cmd   = cmd;
        req.ch    = ch;
        req.off   = off;
        req.wdata = wdata;
        req.line  = line;
        i_in_valid    <= 1'b1;
        i_command     <= cmd;
        i_channel     <= ch;
        i_byte_offset <= off;
        i_write_data  <= wdata;
        i_line_byte   <= line;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        book.note_request(req);
        requests_taken++;
        if (requests_taken % 50 == 0) begin
            case ($urandom_range(0, 2))
                0: send_idle_pct = 0;
                1: send_idle_pct = 8;
                default: send_idle_pct = 25;
            endcase
        end
        @(negedge i_clk);
        if (!quiet_tail && $urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
    endtask

    // Stimulus
    initial begin
        logic [31:0] v;
        logic [7:0]  off;
        bit          ch;
        bit [1:0]    mode;
        int          pick;

        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_command     = CMD_READ;
        i_channel     = 1'b0;
        i_byte_offset = '0;
        i_write_data  = '0;
        i_line_byte   = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part. The input stalls during the clearing sweep; the send
        // task simply waits it out.
        send_request(CMD_READ,  1'b0, OFF_STATUS, 32'h0, 8'h00);          // flags clear after reset
        send_request(CMD_READ,  1'b1, 8'h6C, 32'h0, 8'h00);               // shadow zero after sweep
        // data write with no loopback takes the line byte, enable or not
        send_request(CMD_WRITE, 1'b0, OFF_DATA, 32'hFFFF_FFFF, 8'hA5);
        send_request(CMD_READ,  1'b0, OFF_DATA, 32'h0, 8'hFF);
        send_request(CMD_READ,  1'b0, OFF_STATUS, 32'h0, 8'h00);
        // enable: tx-empty set, rx-full cleared
        send_request(CMD_WRITE, 1'b0, OFF_CTRL, 32'hFFFF_FFFF, 8'h00);
        send_request(CMD_READ,  1'b0, OFF_STATUS, 32'h0, 8'h00);
        send_request(CMD_READ,  1'b0, OFF_CTRL, 32'h0, 8'h00);            // shadow of control
        // direct loopback echoes the whole word
        send_request(CMD_WRITE, 1'b0, OFF_CTRL2, 32'h0002_0000, 8'h00);
        send_request(CMD_WRITE, 1'b0, OFF_DATA, 32'hFFFF_FFFF, 8'h00);
        send_request(CMD_READ,  1'b0, OFF_DATA, 32'h0, 8'h00);
        // inverting loopback echoes the inverted low byte
        send_request(CMD_WRITE, 1'b0, OFF_CTRL2, 32'h0001_0000, 8'h00);
        send_request(CMD_WRITE, 1'b0, OFF_DATA, 32'h1234_5600, 8'h3C);
        send_request(CMD_READ,  1'b0, OFF_DATA, 32'h0, 8'h00);
        // clear everything; tx-empty comes back while enabled
        send_request(CMD_WRITE, 1'b0, OFF_CLEAR, 32'hFFFF_FFFF, 8'h00);
        send_request(CMD_READ,  1'b0, OFF_STATUS, 32'h0, 8'h00);
        // disable clears all flags
        send_request(CMD_WRITE, 1'b0, OFF_CTRL, 32'hFFFF_FFFE, 8'h00);
        send_request(CMD_READ,  1'b0, OFF_STATUS, 32'h0, 8'h00);
        // past the shadow: writes dropped, reads zero
        send_request(CMD_WRITE, 1'b1, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
        send_request(CMD_READ,  1'b1, 8'hFF, 32'h0, 8'h00);
        send_request(CMD_WRITE, 1'b1, 8'h70, 32'hDEAD_BEEF, 8'h00);
        send_request(CMD_READ,  1'b1, 8'h70, 32'h0, 8'h00);
        // unaligned write into the control-2 word: inverting without the latch
        send_request(CMD_WRITE, 1'b1, 8'h0D, 32'h0001_0000, 8'h00);
        send_request(CMD_WRITE, 1'b1, OFF_DATA, 32'h0000_00F0, 8'h77);
        send_request(CMD_READ,  1'b1, OFF_DATA, 32'h0, 8'h00);

        // Random part: mostly complete transfers with random content, the rest
        // single accesses anywhere in the window.
        while (requests_taken < 25 + RANDOM_REQUESTS) begin
            if (requests_taken >= 25 + RANDOM_REQUESTS - QUIET_TAIL) quiet_tail = 1'b1;
            ch = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 9) < 7) begin
                if ($urandom_range(0, 2) != 0) begin
                    v = $urandom();
                    v[BIT_ENABLE] = ($urandom_range(0, 4) != 0);
                    send_request(CMD_WRITE, ch, OFF_CTRL, v, 8'($urandom_range(0, 255)));
                end
                if ($urandom_range(0, 1) != 0) begin
                    mode = 2'($urandom_range(0, 3));
                    v = $urandom();
                    v[BIT_LOOP_INV]    = mode[0];
                    v[BIT_LOOP_DIRECT] = mode[1];
                    send_request(CMD_WRITE, ch, OFF_CTRL2, v, 8'($urandom_range(0, 255)));
                end
                repeat ($urandom_range(1, 3)) begin
                    send_request(CMD_WRITE, ch, OFF_DATA, $urandom(),
                                 8'($urandom_range(0, 255)));
                    send_request(CMD_READ, ch, OFF_DATA, $urandom(),
                                 8'($urandom_range(0, 255)));
                end
                send_request(CMD_READ, ch, OFF_STATUS, $urandom(), 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1) != 0) begin
                    v = $urandom();
                end else begin
                    v = '0;
                    v[FLAG_TX_EMPTY]   = 1'($urandom_range(0, 1));
                    v[FLAG_RX_FULL]    = 1'($urandom_range(0, 1));
                    v[FLAG_DATA_READY] = 1'($urandom_range(0, 1));
                end
                send_request(CMD_WRITE, ch, OFF_CLEAR, v, 8'($urandom_range(0, 255)));
                send_request(CMD_READ, ch, OFF_STATUS, $urandom(), 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 3) == 0) begin
                    send_request(CMD_READ, ch, hot_offsets[$urandom_range(1, 2)], $urandom(),
                                 8'($urandom_range(0, 255)));
                end
            end else begin
                pick = int'($urandom_range(0, 3));
                case (pick)
                    0: off = 8'($urandom_range(0, 255));
                    1: off = hot_offsets[$urandom_range(0, 4)];
                    2: off = {6'($urandom_range(0, SHADOW_WORDS - 1)), 2'($urandom_range(0, 3))};
                    default: off = 8'($urandom_range(8'h70, 8'hFF));
                endcase
                send_request($urandom_range(0, 1) ? CMD_WRITE : CMD_READ, ch, off, $urandom(),
                             8'($urandom_range(0, 255)));
            end
        end
        i_in_valid <= 1'b0;

        // Drain, then allow for the pipeline latency before judging.
        while (book.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (book.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire
